FILE: src/tgib_pkg.sv
// ----------------------------------------------------------------------------
// tgib_pkg
// Shared sizes, codes and types of the interleaved text glyph blit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tgib_pkg;

  // Geometry of the glyph store and of the text screen
  localparam int GLYPH_ROWS   = 14;
  localparam int CODE_COUNT   = 256;
  localparam int TEXT_LINES   = 25;
  localparam int TEXT_COLS    = 80;
  localparam int SCREEN_LINES = 348;
  localparam int STORE_DEPTH  = GLYPH_ROWS * CODE_COUNT;

  // Field and internal widths
  localparam int CODE_W  = 8;
  localparam int ROW_W   = 4;
  localparam int PAT_W   = 8;
  localparam int LINE_W  = 5;
  localparam int COL_W   = 7;
  localparam int BANK_W  = 2;
  localparam int BROW_W  = 7;
  localparam int BYTE_W  = 7;
  localparam int PHASE_W = 3;
  localparam int SCAN_W  = 9;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // Kind of an input beat, carried on tuser
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

  // Draw command handed from the input decode to the row sequencer
  typedef struct packed {
    logic [ADDR_W-1:0]  base;   // store address of glyph row zero
    logic [SCAN_W-1:0]  scan;   // first scan line of the cell
    logic [BYTE_W-1:0]  lbyte;  // left byte index
    logic [PHASE_W-1:0] phase;  // column phase, text_col mod 8
  } draw_cmd_t;

  // Tag that travels with one glyph row read
  typedef struct packed {
    logic [SCAN_W-1:0]  scan;
    logic [BYTE_W-1:0]  lbyte;
    logic [PHASE_W-1:0] phase;
    logic               last;
  } row_tag_t;

  // Store address of one glyph row: code*GLYPH_ROWS + row
  function automatic logic [ADDR_W-1:0] glyph_addr(input logic [CODE_W-1:0] code,
                                                   input logic [ROW_W-1:0]  row);
    glyph_addr = ADDR_W'(code) * ADDR_W'(GLYPH_ROWS) + ADDR_W'(row);
  endfunction

endpackage

`default_nettype wire

FILE: src/tgib_glyph_ram.sv
// ----------------------------------------------------------------------------
// tgib_glyph_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tgib_glyph_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/tgib_row_seq.sv
// ----------------------------------------------------------------------------
// tgib_row_seq
// Walks the glyph rows of one draw, issuing one store read per cycle and
// tracking the read in flight; the next read waits until the output takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tgib_row_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start_i,
  input  wire tgib_pkg::draw_cmd_t       cmd_i,
  input  wire logic                      move_i,
  output logic                           busy_o,
  output logic                           rd_en_o,
  output logic [tgib_pkg::ADDR_W-1:0]    rd_addr_o,
  output logic                           s1_valid_o,
  output tgib_pkg::row_tag_t             s1_tag_o
);

  import tgib_pkg::*;

  logic              active_r, active_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [BYTE_W-1:0] lbyte_r, lbyte_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  row_tag_t          s1_tag_r, s1_tag_nxt;
  logic              issue;
  logic              row_last;

  // Issue when the in-flight slot is free or drains this cycle
  assign issue    = active_r && (!s1_valid_r || move_i);
  assign row_last = (row_r == ROW_W'(GLYPH_ROWS - 1)) ||
                    (scan_r == SCAN_W'(SCREEN_LINES - 1));

  // Next-state logic
  always_comb begin
    active_nxt   = active_r;
    addr_nxt     = addr_r;
    row_nxt      = row_r;
    scan_nxt     = scan_r;
    lbyte_nxt    = lbyte_r;
    phase_nxt    = phase_r;
    s1_valid_nxt = s1_valid_r;
    s1_tag_nxt   = s1_tag_r;
    if (move_i) begin
      s1_valid_nxt = 1'b0;
    end
    if (issue) begin
      s1_valid_nxt   = 1'b1;
      s1_tag_nxt.scan  = scan_r;
      s1_tag_nxt.lbyte = lbyte_r;
      s1_tag_nxt.phase = phase_r;
      s1_tag_nxt.last  = row_last;
      addr_nxt = addr_r + ADDR_W'(1);
      row_nxt  = row_r + ROW_W'(1);
      scan_nxt = scan_r + SCAN_W'(1);
      if (row_last) begin
        active_nxt = 1'b0;
      end
    end
    if (start_i) begin
      active_nxt = 1'b1;
      addr_nxt   = cmd_i.base;
      row_nxt    = '0;
      scan_nxt   = cmd_i.scan;
      lbyte_nxt  = cmd_i.lbyte;
      phase_nxt  = cmd_i.phase;
    end
  end

  // Hold control and walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    addr_r   <= addr_nxt;
    row_r    <= row_nxt;
    scan_r   <= scan_nxt;
    lbyte_r  <= lbyte_nxt;
    phase_r  <= phase_nxt;
    s1_tag_r <= s1_tag_nxt;
  end

  assign busy_o     = active_r;
  assign rd_en_o    = issue;
  assign rd_addr_o  = addr_r;
  assign s1_valid_o = s1_valid_r;
  assign s1_tag_o   = s1_tag_r;

  // A new draw never starts over one still walking its rows
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !active_r)
    else $error("draw started while sequencer busy");

  // A read never overwrites a row the output stage has not taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en_o |-> (!s1_valid_r || move_i))
    else $error("read issued over pending row");

  // Issuing the final row ends the walk
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && row_last && !start_i) |=> !active_r)
    else $error("walk continued past final row");

  // The row counter stays inside the glyph cell
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (row_r < ROW_W'(GLYPH_ROWS)))
    else $error("glyph row counter out of range");

endmodule

`default_nettype wire

FILE: src/tgib_mask_stage.sv
// ----------------------------------------------------------------------------
// tgib_mask_stage
// Shifts one glyph byte across two framebuffer bytes and holds the result
// beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgib_mask_stage (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     s1_valid_i,
  input  wire tgib_pkg::row_tag_t       s1_tag_i,
  input  wire logic [tgib_pkg::PAT_W-1:0] glyph_i,
  output logic                          move_o,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [31:0]                   out_tdata,
  output logic                          out_tlast
);

  import tgib_pkg::*;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           data_r, data_nxt;
  logic                  last_r, last_nxt;
  logic [2*PAT_W-1:0]    wide;
  logic [3:0]            shift;

  // Take the pending row when the output register is free or drains
  assign move_o = s1_valid_i && (!out_valid_r || out_tready);

  // Shift right by column phase plus one across the byte pair
  assign shift = {1'b0, s1_tag_i.phase} + 4'd1;
  assign wide  = {glyph_i, {PAT_W{1'b0}}} >> shift;

  always_comb begin
    out_valid_nxt = out_valid_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (move_o) begin
      out_valid_nxt = 1'b1;
      data_nxt = {wide[PAT_W-1:0],
                  wide[2*PAT_W-1:PAT_W],
                  s1_tag_i.lbyte,
                  s1_tag_i.scan[SCAN_W-1:BANK_W],
                  s1_tag_i.scan[BANK_W-1:0]};
      last_nxt = s1_tag_i.last;
    end
  end

  // Hold the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

FILE: src/text_glyph_interleaved_blit_unit.sv
// Flow: an accepted draw beat starts the row sequencer; each glyph row read
// then passes the store's read register and the output register.
// Throughput: one glyph row per cycle while the receiver does not stall, set by
// the single read port of the glyph store; a draw holds off the input until its
// last row read issues, while a load does not hold off the input.
// Reset (rst_n low, synchronous) clears only the sequencer flags and output valid.
// ----------------------------------------------------------------------------
// text_glyph_interleaved_blit_unit
// Overlays text characters into a four-way interleaved monochrome frame by
// emitting per-scan-line OR masks for two adjacent framebuffer bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_interleaved_blit_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // char_code[7:0], glyph_row[11:8], pattern[19:12], text_line[24:20],
  // text_col[31:25]
  input  wire logic [31:0] in_tdata,
  // action[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // bank[1:0], bank_row[8:2], left_byte[15:9], left_bits[23:16],
  // right_bits[31:24]
  output logic [31:0]      out_tdata,
  // last
  output logic             out_tlast
);

  import tgib_pkg::*;

  logic [CODE_W-1:0] in_code;
  logic [ROW_W-1:0]  in_row;
  logic [PAT_W-1:0]  in_pat;
  logic [LINE_W-1:0] in_line;
  logic [COL_W-1:0]  in_col;
  logic              in_beat;
  logic              is_draw;
  logic              load_ok;
  logic              draw_ok;
  logic [SCAN_W-1:0] start_scan;
  logic              wr_en;
  logic              start;
  draw_cmd_t         cmd;
  logic              busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PAT_W-1:0]  rd_data;
  logic              s1_valid;
  row_tag_t          s1_tag;
  logic              move;

  // Unpack the input beat
  assign in_code = in_tdata[7:0];
  assign in_row  = in_tdata[11:8];
  assign in_pat  = in_tdata[19:12];
  assign in_line = in_tdata[24:20];
  assign in_col  = in_tdata[31:25];
  assign is_draw = (action_t'(in_tuser) == ACT_DRAW);

  // Stall new beats while a draw is still reading the store
  assign in_tready = !busy;
  assign in_beat   = in_tvalid && in_tready;

  // Range checks; out-of-range beats are dropped
  assign start_scan = SCAN_W'(in_line) * SCAN_W'(GLYPH_ROWS);
  assign load_ok = (int'(in_code) < CODE_COUNT) && (int'(in_row) < GLYPH_ROWS);
  assign draw_ok = (int'(in_code) < CODE_COUNT) && (int'(in_line) < TEXT_LINES) &&
                   (int'(in_col) < TEXT_COLS) && (int'(start_scan) < SCREEN_LINES);

  assign wr_en = in_beat && !is_draw && load_ok;
  assign start = in_beat && is_draw && draw_ok;

  // Draw command: col*9/8 is col plus col/8
  assign cmd.base  = glyph_addr(in_code, '0);
  assign cmd.scan  = start_scan;
  assign cmd.lbyte = BYTE_W'(in_col) + BYTE_W'(in_col >> 3);
  assign cmd.phase = in_col[PHASE_W-1:0];

  tgib_glyph_ram #(
    .WIDTH (PAT_W),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (glyph_addr(in_code, in_row)),
    .wr_data (in_pat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tgib_row_seq u_row_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .cmd_i      (cmd),
    .move_i     (move),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_valid_o (s1_valid),
    .s1_tag_o   (s1_tag)
  );

  tgib_mask_stage u_mask_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid_i (s1_valid),
    .s1_tag_i   (s1_tag),
    .glyph_i    (rd_data),
    .move_o     (move),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: bench/tgib_blit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tgib_blit_checker
// Watches both stream channels of the glyph blit unit. It keeps its own copy
// of the glyph store, works out the framebuffer updates for every accepted
// draw beat, and compares each result beat field by field, oldest first.
// ----------------------------------------------------------------------------

module tgib_blit_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending
);

  import tgib_pkg::*;

  // One framebuffer update as carried on the result channel
  typedef struct packed {
    logic [1:0] bank;
    logic [6:0] bank_row;
    logic [6:0] left_byte;
    logic [7:0] left_bits;
    logic [7:0] right_bits;
    logic       last;
  } fb_update_t;

  logic [7:0] glyph_copy [0:STORE_DEPTH-1];
  fb_update_t expected_updates [$];
  int         mismatches;

  initial begin
    mismatches = 0;
    fail_count = 0;
    pending    = 0;
    for (int i = 0; i < STORE_DEPTH; i++) glyph_copy[i] = 8'h00;
  end

  // Queue the row updates one draw beat leads to
  task automatic plan_cell_updates(input int code, input int line, input int col);
    int         rows;
    int         scan;
    int         addr;
    logic [2:0] phase;
    logic [15:0] wide;
    fb_update_t upd;
    if (code >= CODE_COUNT || line >= TEXT_LINES || col >= TEXT_COLS) return;
    // Clip rows that fall below the bottom of the screen
    rows = SCREEN_LINES - line * GLYPH_ROWS;
    if (rows > GLYPH_ROWS) rows = GLYPH_ROWS;
    phase = col[2:0];
    for (int r = 0; r < rows; r++) begin
      scan = line * GLYPH_ROWS + r;
      addr = code * GLYPH_ROWS + r;
      wide = {glyph_copy[addr], 8'h00} >> (phase + 1);
      upd.bank       = scan[1:0];
      upd.bank_row   = scan[8:2];
      upd.left_byte  = 7'((col * 9) / 8);
      upd.left_bits  = wide[15:8];
      upd.right_bits = wide[7:0];
      upd.last       = (r == rows - 1);
      expected_updates.push_back(upd);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fb_update_t got;
    fb_update_t want;
    action_t    act;
    if (rst_n) begin
      // Compare a result beat with the oldest expectation
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[8:2], out_tdata[15:9], out_tdata[23:16],
               out_tdata[31:24], out_tlast};
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h/%b",
                   $time, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = expected_updates.pop_front();
          check_field("bank", want.bank, got.bank);
          check_field("bank_row", want.bank_row, got.bank_row);
          check_field("left_byte", want.left_byte, got.left_byte);
          check_field("left_bits", want.left_bits, got.left_bits);
          check_field("right_bits", want.right_bits, got.right_bits);
          check_field("last", want.last, got.last);
        end
      end
      // Apply a load or plan a draw for each input beat
      if (in_tvalid && in_tready) begin
        act = action_t'(in_tuser);
        if (act == ACT_LOAD) begin
          if (in_tdata[11:8] < GLYPH_ROWS)
            glyph_copy[in_tdata[7:0] * GLYPH_ROWS + in_tdata[11:8]] = in_tdata[19:12];
        end else begin
          plan_cell_updates(in_tdata[7:0], in_tdata[24:20], in_tdata[31:25]);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_updates.size();
  end

endmodule

FILE: bench/text_glyph_interleaved_blit_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_glyph_interleaved_blit_unit_tb
// Drives glyph loads and character draws into the blit unit with random gaps
// and receiver stalls, including one long hold-off, and reports the verdict
// from the checker's failure count and pending count.
// ----------------------------------------------------------------------------

module text_glyph_interleaved_blit_unit_tb;

  import tgib_pkg::*;

  localparam int RANDOM_BEATS = 135;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;

  int          cycle_count;
  int          beats_sent;
  int          updates_taken;
  int          tx_calm_left;
  int          rx_calm_left;
  bit          code_ready [0:CODE_COUNT-1];
  int          ready_codes [$];

  text_glyph_interleaved_blit_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  tgib_blit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles and end a hung run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one input beat after a random gap and wait until it is taken
  task automatic send_beat(input action_t act, input int code, input int row,
                           input int pat, input int line, input int col);
    int gap;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 9) == 0) tx_calm_left = $urandom_range(8, 24);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {col[6:0], line[4:0], pat[7:0], row[3:0], code[7:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Write all rows of one glyph in shuffled order with the given patterns
  task automatic load_glyph(input int code, input logic [7:0] pats [GLYPH_ROWS]);
    int order [GLYPH_ROWS];
    int j;
    int tmp;
    for (int i = 0; i < GLYPH_ROWS; i++) order[i] = i;
    for (int i = GLYPH_ROWS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < GLYPH_ROWS; i++)
      send_beat(ACT_LOAD, code, order[i], pats[order[i]], $urandom_range(0, 31),
                $urandom_range(0, 127));
    if (!code_ready[code]) begin
      code_ready[code] = 1'b1;
      ready_codes.push_back(code);
    end
  endtask

  task automatic draw_char(input int code, input int line, input int col);
    send_beat(ACT_DRAW, code, $urandom_range(0, 15), $urandom_range(0, 255), line, col);
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off
  initial begin
    int gap;
    out_tready    <= 1'b0;
    updates_taken = 0;
    rx_calm_left  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        updates_taken++;
        if (updates_taken == HOLD_AT) begin
          gap = HOLD_CYCLES;
        end else if (rx_calm_left > 0) begin
          rx_calm_left--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 11);
          if ($urandom_range(0, 9) == 0) rx_calm_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [7:0] pats [GLYPH_ROWS];
    int pick;
    int code;
    int line;
    int col;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= ACT_LOAD;
    beats_sent   = 0;
    tx_calm_left = 0;
    for (int i = 0; i < CODE_COUNT; i++) code_ready[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: top code with extreme patterns, ignored loads, edge draws
    pats = '{8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h00, 8'hC3,
             8'h3C, 8'h7E, 8'h81, 8'hF0, 8'h0F, 8'hFE, 8'h7F};
    load_glyph(255, pats);
    send_beat(ACT_LOAD, 255, 14, 8'h00, 0, 0);
    send_beat(ACT_LOAD, 0, 15, 8'hFF, 31, 127);
    draw_char(255, 0, 0);
    draw_char(255, TEXT_LINES - 1, TEXT_COLS - 1);
    draw_char(255, TEXT_LINES - 1, 7);
    draw_char(255, 12, 39);
    draw_char(255, TEXT_LINES, 0);
    draw_char(255, 0, TEXT_COLS);
    draw_char(255, 31, 127);

    // Random: mostly valid draws of loaded glyphs, some loads and noise
    while (beats_sent < 25 + RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        pick = $urandom_range(0, 9);
        code = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255);
        for (int i = 0; i < GLYPH_ROWS; i++) pats[i] = 8'($urandom_range(0, 255));
        load_glyph(code, pats);
      end else if (pick < 14) begin
        // Out-of-range row is dropped; in-range row overwrites one entry
        send_beat(ACT_LOAD, $urandom_range(0, 255), $urandom_range(0, 15),
                  $urandom_range(0, 255), $urandom_range(0, 31), $urandom_range(0, 127));
      end else if (pick < 22) begin
        code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
        if ($urandom_range(0, 1) == 0)
          draw_char(code, $urandom_range(TEXT_LINES, 31), $urandom_range(0, 127));
        else
          draw_char(code, $urandom_range(0, 31), $urandom_range(TEXT_COLS, 127));
      end else begin
        code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
        pick = $urandom_range(0, 19);
        line = (pick < 3) ? TEXT_LINES - 1 : (pick < 5) ? 0 : $urandom_range(0, TEXT_LINES - 1);
        pick = $urandom_range(0, 19);
        col  = (pick < 3) ? TEXT_COLS - 1 : (pick < 5) ? 0 : $urandom_range(0, TEXT_COLS - 1);
        draw_char(code, line, col);
      end
    end
    in_tvalid <= 1'b0;

    // Drain outstanding updates, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tgib_pkg.sv
src/tgib_glyph_ram.sv
src/tgib_row_seq.sv
src/tgib_mask_stage.sv
src/text_glyph_interleaved_blit_unit.sv
bench/tgib_blit_checker.sv
bench/text_glyph_interleaved_blit_unit_tb.sv
